// ===== rtl/core/sim_pkg.sv =====
`default_nettype none

package sim_pkg;

    // configuration register indexes
    localparam int unsigned NUM_REGS   = 8;
    localparam int unsigned REG_IDX_W  = 3;
    localparam int unsigned REG_DATA_W = 12;

    localparam logic [REG_IDX_W-1:0] REG_TEMP_WARN_LOW  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_WARN_HIGH = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_HALT_LOW  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_HALT_HIGH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PRESS_LOW      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PRESS_HIGH     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FAN_ON_TEMP    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_FAN_OFF_TEMP   = 3'd7;

    // register reset values
    localparam logic [REG_DATA_W-1:0] RST_TEMP_WARN_LOW  = 12'd560;
    localparam logic [REG_DATA_W-1:0] RST_TEMP_WARN_HIGH = 12'd608;
    localparam logic [REG_DATA_W-1:0] RST_TEMP_HALT_LOW  = 12'd512;
    localparam logic [REG_DATA_W-1:0] RST_TEMP_HALT_HIGH = 12'd656;
    localparam logic [REG_DATA_W-1:0] RST_PRESS_LOW      = 12'd100;
    localparam logic [REG_DATA_W-1:0] RST_PRESS_HIGH     = 12'd200;
    localparam logic [REG_DATA_W-1:0] RST_FAN_ON_TEMP    = 12'd624;
    localparam logic [REG_DATA_W-1:0] RST_FAN_OFF_TEMP   = 12'd592;

    // pressure confirm window in ms
    localparam logic [31:0] CONFIRM_MS = 32'd3000;

    // fault codes
    localparam logic [2:0] FAULT_NONE  = 3'd0;
    localparam logic [2:0] FAULT_AIR   = 3'd1;
    localparam logic [2:0] FAULT_TLOW  = 3'd2;
    localparam logic [2:0] FAULT_THIGH = 3'd3;
    localparam logic [2:0] FAULT_PRESS = 3'd4;

    // message codes
    localparam logic [2:0] MSG_NONE    = 3'd0;
    localparam logic [2:0] MSG_RESUMED = 3'd1;
    localparam logic [2:0] MSG_STILL   = 3'd2;
    localparam logic [2:0] MSG_HALTED  = 3'd3;
    localparam logic [2:0] MSG_ALERT   = 3'd4;

    typedef struct packed {
        logic signed [11:0] temp_warn_low;
        logic signed [11:0] temp_warn_high;
        logic signed [11:0] temp_halt_low;
        logic signed [11:0] temp_halt_high;
        logic        [11:0] press_low;
        logic        [11:0] press_high;
        logic signed [11:0] fan_on_temp;
        logic signed [11:0] fan_off_temp;
    } cfg_t;

    typedef struct packed {
        logic signed [11:0] temperature;
        logic        [11:0] pressure_sample;
        logic               air_seen;
        logic               recheck_pressed;
        logic        [31:0] time_ms;
    } sample_t;

    typedef struct packed {
        logic       halted;
        logic [2:0] fault;
        logic       temp_warning;
        logic       resume_ok;
        logic [2:0] message_kind;
        logic       warning_led;
        logic       buzzer;
        logic       pump_kill;
        logic       fan_drive;
        logic       view_cycle_allowed;
        logic       force_redraw;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/sim_cfg_regs.sv =====
`default_nettype none

module sim_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sim_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [sim_pkg::REG_DATA_W-1:0] cfg_wdata,
    output      sim_pkg::cfg_t                   cfg
);
    import sim_pkg::*;

    logic [REG_DATA_W-1:0] regs_reg [NUM_REGS];

    // register file with write enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[REG_TEMP_WARN_LOW]  <= RST_TEMP_WARN_LOW;
            regs_reg[REG_TEMP_WARN_HIGH] <= RST_TEMP_WARN_HIGH;
            regs_reg[REG_TEMP_HALT_LOW]  <= RST_TEMP_HALT_LOW;
            regs_reg[REG_TEMP_HALT_HIGH] <= RST_TEMP_HALT_HIGH;
            regs_reg[REG_PRESS_LOW]      <= RST_PRESS_LOW;
            regs_reg[REG_PRESS_HIGH]     <= RST_PRESS_HIGH;
            regs_reg[REG_FAN_ON_TEMP]    <= RST_FAN_ON_TEMP;
            regs_reg[REG_FAN_OFF_TEMP]   <= RST_FAN_OFF_TEMP;
        end
        else if (cfg_we)
        begin
            regs_reg[cfg_index] <= cfg_wdata;
        end
    end

    // present as named thresholds
    always_comb
    begin
        cfg.temp_warn_low  = regs_reg[REG_TEMP_WARN_LOW];
        cfg.temp_warn_high = regs_reg[REG_TEMP_WARN_HIGH];
        cfg.temp_halt_low  = regs_reg[REG_TEMP_HALT_LOW];
        cfg.temp_halt_high = regs_reg[REG_TEMP_HALT_HIGH];
        cfg.press_low      = regs_reg[REG_PRESS_LOW];
        cfg.press_high     = regs_reg[REG_PRESS_HIGH];
        cfg.fan_on_temp    = regs_reg[REG_FAN_ON_TEMP];
        cfg.fan_off_temp   = regs_reg[REG_FAN_OFF_TEMP];
    end

`ifndef SYNTH
    a_fan_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_FAN_ON_TEMP |=> cfg.fan_on_temp == $past(cfg_wdata))
        else $error("fan on threshold not written");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sim_core.sv =====
`default_nettype none

module sim_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire sim_pkg::cfg_t    cfg,
    input  wire sim_pkg::sample_t smp,
    input  wire logic    adv,
    output sim_pkg::result_t res
);
    import sim_pkg::*;

    logic        halt_latched_reg, halt_latched_next;
    logic [2:0]  latched_fault_reg, latched_fault_next;
    logic        press_timing_reg, press_timing_next;
    logic [31:0] press_start_reg, press_start_next;
    logic        warn_was_on_reg, warn_was_on_next;
    logic        fan_reg, fan_next;

    logic signed [11:0] t;
    logic        temp_low, temp_high, press_out, press_reached, press_confirmed;
    logic [31:0] elapsed;
    logic [2:0]  cur_fault;
    logic        warn_band;

    // threshold compares
    always_comb
    begin
        t               = smp.temperature;
        temp_low        = t <= cfg.temp_halt_low;
        temp_high       = t >= cfg.temp_halt_high;
        press_out       = (smp.pressure_sample < cfg.press_low)
                       || (smp.pressure_sample > cfg.press_high);
        press_reached   = !smp.air_seen && !temp_low && !temp_high;
        elapsed         = smp.time_ms - press_start_reg;
        press_confirmed = press_out && press_timing_reg && (elapsed >= CONFIRM_MS);
        warn_band       = (t < cfg.temp_warn_low) || (t > cfg.temp_warn_high);
    end

    // fault priority
    always_comb
    begin
        if (smp.air_seen)
            cur_fault = FAULT_AIR;
        else if (temp_low)
            cur_fault = FAULT_TLOW;
        else if (temp_high)
            cur_fault = FAULT_THIGH;
        else if (press_confirmed)
            cur_fault = FAULT_PRESS;
        else
            cur_fault = FAULT_NONE;
    end

    // pressure timer, only touched when the check is reached
    always_comb
    begin
        press_timing_next = press_timing_reg;
        press_start_next  = press_start_reg;
        if (press_reached)
        begin
            press_timing_next = press_out;
            if (press_out && !press_timing_reg)
                press_start_next = smp.time_ms;
        end
    end

    // fan thermostat with hysteresis
    always_comb
    begin
        fan_next = fan_reg;
        if (!fan_reg && (t > cfg.fan_on_temp))
            fan_next = 1'b1;
        else if (fan_reg && (t <= cfg.fan_off_temp))
            fan_next = 1'b0;
    end

    // halt latch and result
    always_comb
    begin
        halt_latched_next  = halt_latched_reg;
        latched_fault_next = latched_fault_reg;
        warn_was_on_next   = warn_was_on_reg;
        res                = '0;
        res.fan_drive      = fan_next;
        if (halt_latched_reg)
        begin
            res.halted      = 1'b1;
            res.fault       = latched_fault_reg;
            res.warning_led = 1'b1;
            res.buzzer      = 1'b1;
            res.pump_kill   = 1'b1;
            if (smp.recheck_pressed)
            begin
                if (cur_fault == FAULT_NONE)
                begin
                    halt_latched_next      = 1'b0;
                    latched_fault_next     = FAULT_NONE;
                    res.halted             = 1'b0;
                    res.fault              = FAULT_NONE;
                    res.warning_led        = 1'b0;
                    res.buzzer             = 1'b0;
                    res.pump_kill          = 1'b0;
                    res.resume_ok          = 1'b1;
                    res.message_kind       = MSG_RESUMED;
                    res.force_redraw       = 1'b1;
                    res.view_cycle_allowed = 1'b1;
                end
                else
                begin
                    latched_fault_next = cur_fault;
                    res.fault          = cur_fault;
                    res.message_kind   = MSG_STILL;
                end
            end
        end
        else if (cur_fault != FAULT_NONE)
        begin
            halt_latched_next  = 1'b1;
            latched_fault_next = cur_fault;
            res.halted         = 1'b1;
            res.fault          = cur_fault;
            res.warning_led    = 1'b1;
            res.buzzer         = 1'b1;
            res.pump_kill      = 1'b1;
            res.message_kind   = MSG_HALTED;
        end
        else if (warn_band)
        begin
            res.warning_led  = 1'b1;
            res.temp_warning = 1'b1;
            if (!warn_was_on_reg)
                res.message_kind = MSG_ALERT;
            warn_was_on_next = 1'b1;
        end
        else
        begin
            res.force_redraw       = warn_was_on_reg;
            res.view_cycle_allowed = 1'b1;
            warn_was_on_next       = 1'b0;
        end
    end

    // monitor state, updated once per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_latched_reg  <= 1'b0;
            latched_fault_reg <= FAULT_NONE;
            press_timing_reg  <= 1'b0;
            press_start_reg   <= '0;
            warn_was_on_reg   <= 1'b0;
            fan_reg           <= 1'b0;
        end
        else if (adv)
        begin
            halt_latched_reg  <= halt_latched_next;
            latched_fault_reg <= latched_fault_next;
            press_timing_reg  <= press_timing_next;
            press_start_reg   <= press_start_next;
            warn_was_on_reg   <= warn_was_on_next;
            fan_reg           <= fan_next;
        end
    end

`ifndef SYNTH
    a_halt_drives: assert property (@(posedge clk) disable iff (!rst_n)
        res.halted |-> res.buzzer && res.pump_kill && res.warning_led)
        else $error("halted without alarm drives");
    a_halt_latches: assert property (@(posedge clk) disable iff (!rst_n)
        adv && res.halted |=> halt_latched_reg && latched_fault_reg != FAULT_NONE)
        else $error("halt not latched");
    a_resume_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res.resume_ok |-> !res.halted && res.fault == FAULT_NONE && halt_latched_reg)
        else $error("resume with fault");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/safety_interlock_monitor_top.sv =====
`default_nettype none

// accepted samples are held in the input register, results in the output register
// throughput: one sample per cycle unless the output is stalled; the evaluation is a single compare/subtract pass
// a stalled output holds its result while one more sample waits in the input register
// reset: async active low; thresholds return to defaults, halt latch, pressure
// timer, warning flag and fan state clear; no clearing pass

module safety_interlock_monitor_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [11:0] temperature,
    input  wire logic [11:0] pressure_sample,
    input  wire logic        air_seen,
    input  wire logic        recheck_pressed,
    input  wire logic [31:0] time_ms,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic        halted,
    output      logic [2:0]  fault,
    output      logic        temp_warning,
    output      logic        resume_ok,
    output      logic [2:0]  message_kind,
    output      logic        warning_led,
    output      logic        buzzer,
    output      logic        pump_kill,
    output      logic        fan_drive,
    output      logic        view_cycle_allowed,
    output      logic        force_redraw,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [11:0] cfg_wdata
);
    import sim_pkg::*;

    cfg_t    cfg;
    sample_t smp_reg;
    result_t res;
    result_t res_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    adv;

    // handshake: input stage moves on when the output register is free
    assign adv      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            smp_reg.temperature     <= temperature;
            smp_reg.pressure_sample <= pressure_sample;
            smp_reg.air_seen        <= air_seen;
            smp_reg.recheck_pressed <= recheck_pressed;
            smp_reg.time_ms         <= time_ms;
        end
        if (adv)
            res_reg <= res;
    end

    sim_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sim_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .smp   (smp_reg),
        .adv   (adv),
        .res   (res)
    );

    // output ports
    assign out_valid          = out_valid_reg;
    assign halted             = res_reg.halted;
    assign fault              = res_reg.fault;
    assign temp_warning       = res_reg.temp_warning;
    assign resume_ok          = res_reg.resume_ok;
    assign message_kind       = res_reg.message_kind;
    assign warning_led        = res_reg.warning_led;
    assign buzzer             = res_reg.buzzer;
    assign pump_kill          = res_reg.pump_kill;
    assign fan_drive          = res_reg.fan_drive;
    assign view_cycle_allowed = res_reg.view_cycle_allowed;
    assign force_redraw       = res_reg.force_redraw;

`ifndef SYNTH
    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("evaluated sample lost");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !adv)
        else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire
